>>> hdl/sgdm_pkg.sv
// shared constants, types and saturation helper for the sgd momentum weight update block
// no dependencies
`default_nettype none

package sgdm_pkg;

   localparam int DATA_W     = 32;
   localparam int FACTOR_W   = 24;
   localparam int FRAC_BITS  = 24;
   localparam int BATCH_W    = 16;
   localparam int SET_W      = 4;
   localparam int ELEM_W     = 12;
   localparam int PROD_W     = DATA_W + 1;
   localparam int SUM_W      = DATA_W + 3;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   localparam int DEF_MATRIX_ELEMENTS = 4096;
   localparam int DEF_MATRIX_COUNT    = 16;
   localparam int DEF_VECTOR_LENGTH   = 4096;

   localparam logic MODE_MATRIX = 1'b0;
   localparam logic MODE_VECTOR = 1'b1;

   localparam logic [REG_IDX_W-1:0] REG_LEARNING_RATE   = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_MOMENTUM_FACTOR = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_WEIGHT_DECAY    = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_BATCH_SIZE      = 2'd3;

   localparam logic [FACTOR_W-1:0] RESET_LEARNING_RATE   = 24'd167772;
   localparam logic [FACTOR_W-1:0] RESET_MOMENTUM_FACTOR = 24'd15099494;
   localparam logic [FACTOR_W-1:0] RESET_WEIGHT_DECAY    = 24'd0;
   localparam logic [BATCH_W-1:0]  RESET_BATCH_SIZE      = 16'd1;
   localparam logic [FACTOR_W-1:0] RESET_LR_BATCH        =
      FACTOR_W'(RESET_LEARNING_RATE / RESET_BATCH_SIZE);
   localparam logic [FACTOR_W-1:0] RESET_LR_DECAY        =
      FACTOR_W'((48'(RESET_LEARNING_RATE) * 48'(RESET_WEIGHT_DECAY)) >> FRAC_BITS);

   localparam logic [DATA_W-1:0] S32_MAX = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

   typedef struct packed {
      logic [FACTOR_W-1:0] momentum;
      logic [FACTOR_W-1:0] lr_batch;
      logic [FACTOR_W-1:0] lr_decay;
      logic                busy;
   } factors_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              clip;
   } sat_type;

   function automatic sat_type saturate(input logic [SUM_W-1:0] x);
      sat_type r;
      if ((&x[SUM_W-1:DATA_W-1]) || !(|x[SUM_W-1:DATA_W-1])) begin
         r.value = x[DATA_W-1:0];
         r.clip  = 1'b0;
      end else begin
         r.value = x[SUM_W-1] ? S32_MIN : S32_MAX;
         r.clip  = 1'b1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hdl/sgdm_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// depends on sgdm_pkg for default width
`default_nettype none

module sgdm_ram #(
   parameter int WIDTH = sgdm_pkg::DATA_W,
   parameter int DEPTH = sgdm_pkg::DEF_VECTOR_LENGTH,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/sgdm_scale.sv
// derived scales: bit-serial divider for lr/batch and one multiply for lr*decay
// depends on sgdm_pkg
`default_nettype none

module sgdm_scale (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [sgdm_pkg::FACTOR_W-1:0] learning_rate,
   input  logic [sgdm_pkg::FACTOR_W-1:0] weight_decay,
   input  logic [sgdm_pkg::BATCH_W-1:0]  batch_size,
   output logic [sgdm_pkg::FACTOR_W-1:0] lr_batch,
   output logic [sgdm_pkg::FACTOR_W-1:0] lr_decay,
   output logic                          busy
);
   import sgdm_pkg::*;

   localparam int CNT_W = $clog2(FACTOR_W + 1);

   logic [CNT_W-1:0]      cnt_ff;
   logic [FACTOR_W-1:0]   quo_ff, quo_in;
   logic [BATCH_W-1:0]    rem_ff, rem_in;
   logic [BATCH_W-1:0]    div_ff;
   logic [FACTOR_W-1:0]   lr_batch_ff;
   logic [FACTOR_W-1:0]   lr_decay_ff, lr_decay_in;
   logic [BATCH_W:0]      shifted, diff;
   logic                  fits;
   logic [2*FACTOR_W-1:0] decay_prod;

   always_comb begin
      shifted = {rem_ff, quo_ff[FACTOR_W-1]};
      diff    = shifted - {1'b0, div_ff};
      fits    = shifted >= {1'b0, div_ff};
      rem_in  = fits ? diff[BATCH_W-1:0] : shifted[BATCH_W-1:0];
      quo_in  = {quo_ff[FACTOR_W-2:0], fits};
      decay_prod  = {{FACTOR_W{1'b0}}, learning_rate} * {{FACTOR_W{1'b0}}, weight_decay};
      lr_decay_in = decay_prod[FRAC_BITS +: FACTOR_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         lr_batch_ff <= RESET_LR_BATCH;
         lr_decay_ff <= RESET_LR_DECAY;
      end else if (start) begin
         cnt_ff      <= CNT_W'(FACTOR_W);
         lr_decay_ff <= lr_decay_in;
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            lr_batch_ff <= quo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= learning_rate;
         rem_ff <= '0;
         div_ff <= (batch_size == '0) ? BATCH_W'(1) : batch_size;
      end else if (cnt_ff != '0) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign lr_batch = lr_batch_ff;
   assign lr_decay = lr_decay_ff;
   assign busy     = start || (cnt_ff != '0);

endmodule

`default_nettype wire

>>> hdl/sgdm_csr.sv
// configuration registers behind the apb-style port, plus derived scale unit
// depends on sgdm_pkg and sgdm_scale
`default_nettype none

module sgdm_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [sgdm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sgdm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sgdm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   output sgdm_pkg::factors_type           factors
);
   import sgdm_pkg::*;

   logic [FACTOR_W-1:0]  lr_ff, mom_ff, wd_ff;
   logic [BATCH_W-1:0]   batch_ff;
   logic                 start_ff;
   logic                 wr;
   logic [REG_IDX_W-1:0] idx;
   logic [FACTOR_W-1:0]  lr_batch, lr_decay;
   logic                 busy;

   assign wr  = csr_psel && csr_penable && csr_pwrite;
   assign idx = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff    <= RESET_LEARNING_RATE;
         mom_ff   <= RESET_MOMENTUM_FACTOR;
         wd_ff    <= RESET_WEIGHT_DECAY;
         batch_ff <= RESET_BATCH_SIZE;
         start_ff <= 1'b0;
      end else begin
         start_ff <= wr;
         if (wr) begin
            unique case (idx)
               REG_LEARNING_RATE:   lr_ff    <= csr_pwdata[FACTOR_W-1:0];
               REG_MOMENTUM_FACTOR: mom_ff   <= csr_pwdata[FACTOR_W-1:0];
               REG_WEIGHT_DECAY:    wd_ff    <= csr_pwdata[FACTOR_W-1:0];
               REG_BATCH_SIZE:      batch_ff <= csr_pwdata[BATCH_W-1:0];
            endcase
         end
      end
   end

   always_comb begin
      unique case (idx)
         REG_LEARNING_RATE:   csr_prdata = {{(CSR_DATA_W-FACTOR_W){1'b0}}, lr_ff};
         REG_MOMENTUM_FACTOR: csr_prdata = {{(CSR_DATA_W-FACTOR_W){1'b0}}, mom_ff};
         REG_WEIGHT_DECAY:    csr_prdata = {{(CSR_DATA_W-FACTOR_W){1'b0}}, wd_ff};
         REG_BATCH_SIZE:      csr_prdata = {{(CSR_DATA_W-BATCH_W){1'b0}}, batch_ff};
      endcase
   end

   sgdm_scale u_scale (
      .clock         (clock),
      .reset         (reset),
      .start         (start_ff),
      .learning_rate (lr_ff),
      .weight_decay  (wd_ff),
      .batch_size    (batch_ff),
      .lr_batch      (lr_batch),
      .lr_decay      (lr_decay),
      .busy          (busy)
   );

   assign csr_pready        = 1'b1;
   assign factors.momentum  = mom_ff;
   assign factors.lr_batch  = lr_batch;
   assign factors.lr_decay  = lr_decay;
   assign factors.busy      = busy;

endmodule

`default_nettype wire

>>> hdl/sgd_momentum_weight_update.sv
// top level: velocity memories, read-modify-write update pipeline, clear sweep, output skid
// depends on sgdm_pkg, sgdm_ram, sgdm_csr
//
//   port group  dir     transfer at rising edge with
//   req_*       in      req_valid high, req_stall low
//   rsp_*       out     rsp_valid high, rsp_stall low
//   csr_*       in/out  csr_psel, csr_penable, csr_pwrite, csr_pready high (write)
//
// one item per cycle while req_stall is low; its result goes through stages 1, 2, 3 and the output register
// an item on the same velocity entry as the item right before it waits until that one leaves stage 1
//   (velocity loop through the stage 1 multiplier and stage 2 adder)
// after reset a sweep zeroes both memories, max(MATRIX_COUNT*MATRIX_ELEMENTS,
//   VECTOR_LENGTH) entries (65536 at default size), req_stall high meanwhile
// after a csr write req_stall is high while the serial divider forms lr/batch
// a stalled result parks in a skid register; input stalls for output back-pressure only once that is full
`default_nettype none

module sgd_momentum_weight_update #(
   parameter int MATRIX_ELEMENTS = sgdm_pkg::DEF_MATRIX_ELEMENTS,
   parameter int MATRIX_COUNT    = sgdm_pkg::DEF_MATRIX_COUNT,
   parameter int VECTOR_LENGTH   = sgdm_pkg::DEF_VECTOR_LENGTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_mode,
   input  logic [sgdm_pkg::SET_W-1:0]         req_set_index,
   input  logic [sgdm_pkg::ELEM_W-1:0]        req_element_index,
   input  logic signed [sgdm_pkg::DATA_W-1:0] req_weight,
   input  logic signed [sgdm_pkg::DATA_W-1:0] req_gradient,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [sgdm_pkg::DATA_W-1:0] rsp_new_weight,
   output logic                               rsp_saturated,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sgdm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [sgdm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [sgdm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import sgdm_pkg::*;

   localparam int MATRIX_DEPTH = MATRIX_COUNT * MATRIX_ELEMENTS;
   localparam int MADDR_W      = (MATRIX_DEPTH > 1) ? $clog2(MATRIX_DEPTH) : 1;
   localparam int VADDR_W      = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
   localparam int CLEAR_LEN    = (MATRIX_DEPTH > VECTOR_LENGTH) ? MATRIX_DEPTH : VECTOR_LENGTH;
   localparam int CLR_W        = (CLEAR_LEN > 1) ? $clog2(CLEAR_LEN) : 1;
   localparam int MUL_W        = DATA_W + FACTOR_W + 1;

   typedef struct packed {
      logic               mode;
      logic               ok;
      logic [MADDR_W-1:0] maddr;
      logic [VADDR_W-1:0] vaddr;
   } slot_type;

   typedef struct packed {
      slot_type          slot;
      logic [DATA_W-1:0] weight;
      logic [DATA_W-1:0] gradient;
   } stage1_type;

   typedef struct packed {
      slot_type          slot;
      logic [DATA_W-1:0] weight;
      logic [PROD_W-1:0] pv;
      logic [PROD_W-1:0] pg;
      logic [PROD_W-1:0] pd;
   } stage2_type;

   typedef struct packed {
      logic [DATA_W-1:0] weight;
      logic [DATA_W-1:0] v_new;
      logic              clip;
      logic [PROD_W-1:0] pd;
   } stage3_type;

   typedef struct packed {
      logic [DATA_W-1:0] new_weight;
      logic              saturated;
   } result_type;

   function automatic logic same_entry(input slot_type a, input slot_type b);
      return (a.mode == b.mode) &&
             ((a.mode == MODE_VECTOR) ? (a.vaddr == b.vaddr) : (a.maddr == b.maddr));
   endfunction

   factors_type       factors;
   slot_type          req_slot;
   logic [31:0]       set_wide, elem_wide, maddr_wide;
   logic              advance, accept, hazard;

   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff;
   stage1_type        s1_ff, s1_in;
   stage2_type        s2_ff, s2_in;
   stage3_type        s3_ff, s3_in;
   logic              fw_valid_ff;
   slot_type          fw_slot_ff;
   logic [DATA_W-1:0] fw_data_ff;

   logic [DATA_W-1:0] mat_rd_data, vec_rd_data, v_old;
   logic              mat_wr_en, vec_wr_en;
   logic [MADDR_W-1:0] mat_wr_addr;
   logic [VADDR_W-1:0] vec_wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic signed [MUL_W-1:0] pv_full, pg_full, pd_full;
   logic [SUM_W-1:0]  vsum, wsum;
   sat_type           vsat, wsat;

   logic              clr_active_ff;
   logic [CLR_W-1:0]  clr_cnt_ff;

   result_type        result_in, rsp_ff, skid_ff;
   logic              rsp_valid_ff, rsp_valid_in, skid_valid_ff, skid_valid_in;
   logic              rsp_load, skid_load;

   sgdm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .factors     (factors)
   );

   // request decode
   always_comb begin
      set_wide       = {{(32-SET_W){1'b0}}, req_set_index};
      elem_wide      = {{(32-ELEM_W){1'b0}}, req_element_index};
      maddr_wide     = set_wide * 32'(MATRIX_ELEMENTS) + elem_wide;
      req_slot.mode  = req_mode;
      req_slot.maddr = maddr_wide[MADDR_W-1:0];
      req_slot.vaddr = elem_wide[VADDR_W-1:0];
      if (req_mode == MODE_VECTOR) begin
         req_slot.ok = elem_wide < 32'(VECTOR_LENGTH);
      end else begin
         req_slot.ok = (set_wide < 32'(MATRIX_COUNT)) && (elem_wide < 32'(MATRIX_ELEMENTS));
      end
   end

   assign advance   = !skid_valid_ff;
   assign hazard    = s1_valid_ff && s1_ff.slot.ok && req_slot.ok && same_entry(req_slot, s1_ff.slot);
   assign req_stall = clr_active_ff || factors.busy || !advance || hazard;
   assign accept    = req_valid && !req_stall;

   assign s1_in = '{slot: req_slot, weight: req_weight, gradient: req_gradient};

   // stage 1: velocity read with forwarding, three products
   always_comb begin
      if (!s1_ff.slot.ok) begin
         v_old = '0;
      end else if (fw_valid_ff && same_entry(fw_slot_ff, s1_ff.slot)) begin
         v_old = fw_data_ff;
      end else begin
         v_old = (s1_ff.slot.mode == MODE_VECTOR) ? vec_rd_data : mat_rd_data;
      end
      pv_full = $signed(v_old) * $signed({1'b0, factors.momentum});
      pg_full = $signed(s1_ff.gradient) * $signed({1'b0, factors.lr_batch});
      pd_full = $signed(s1_ff.weight) * $signed({1'b0, factors.lr_decay});
      s2_in.slot   = s1_ff.slot;
      s2_in.weight = s1_ff.weight;
      s2_in.pv     = pv_full[MUL_W-1:FRAC_BITS];
      s2_in.pg     = pg_full[MUL_W-1:FRAC_BITS];
      s2_in.pd     = pd_full[MUL_W-1:FRAC_BITS];
   end

   // stage 2: new velocity, written back
   always_comb begin
      vsum = {{2{s2_ff.pv[PROD_W-1]}}, s2_ff.pv} + {{2{s2_ff.pg[PROD_W-1]}}, s2_ff.pg};
      vsat = saturate(vsum);
      s3_in.weight = s2_ff.weight;
      s3_in.v_new  = vsat.value;
      s3_in.clip   = vsat.clip;
      s3_in.pd     = s2_ff.pd;
   end

   // stage 3: new weight
   always_comb begin
      wsum = {{3{s3_ff.weight[DATA_W-1]}}, s3_ff.weight}
           - {{3{s3_ff.v_new[DATA_W-1]}}, s3_ff.v_new}
           - {{2{s3_ff.pd[PROD_W-1]}}, s3_ff.pd};
      wsat = saturate(wsum);
      result_in.new_weight = wsat.value;
      result_in.saturated  = s3_ff.clip || wsat.clip;
   end

   // memory write port: clear sweep or write-back
   always_comb begin
      if (clr_active_ff) begin
         mat_wr_en   = 32'(clr_cnt_ff) < 32'(MATRIX_DEPTH);
         vec_wr_en   = 32'(clr_cnt_ff) < 32'(VECTOR_LENGTH);
         mat_wr_addr = clr_cnt_ff[MADDR_W-1:0];
         vec_wr_addr = clr_cnt_ff[VADDR_W-1:0];
         wr_data     = '0;
      end else begin
         mat_wr_en   = advance && s2_valid_ff && s2_ff.slot.ok && (s2_ff.slot.mode == MODE_MATRIX);
         vec_wr_en   = advance && s2_valid_ff && s2_ff.slot.ok && (s2_ff.slot.mode == MODE_VECTOR);
         mat_wr_addr = s2_ff.slot.maddr;
         vec_wr_addr = s2_ff.slot.vaddr;
         wr_data     = vsat.value;
      end
   end

   sgdm_ram #(.WIDTH(DATA_W), .DEPTH(MATRIX_DEPTH)) u_matrix_ram (
      .clock   (clock),
      .wr_en   (mat_wr_en),
      .wr_addr (mat_wr_addr),
      .wr_data (wr_data),
      .rd_en   (advance),
      .rd_addr (req_slot.maddr),
      .rd_data (mat_rd_data)
   );

   sgdm_ram #(.WIDTH(DATA_W), .DEPTH(VECTOR_LENGTH)) u_vector_ram (
      .clock   (clock),
      .wr_en   (vec_wr_en),
      .wr_addr (vec_wr_addr),
      .wr_data (wr_data),
      .rd_en   (advance),
      .rd_addr (req_slot.vaddr),
      .rd_data (vec_rd_data)
   );

   // output register and skid
   always_comb begin
      rsp_load  = advance ? (s3_valid_ff && (!rsp_valid_ff || !rsp_stall)) : !rsp_stall;
      skid_load = advance && s3_valid_ff && rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      if (skid_load) begin
         skid_valid_in = 1'b1;
      end else if (!advance && !rsp_stall) begin
         skid_valid_in = 1'b0;
      end else begin
         skid_valid_in = skid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         fw_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         clr_active_ff <= 1'b1;
         clr_cnt_ff    <= '0;
      end else begin
         if (advance) begin
            s1_valid_ff <= accept;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
            fw_valid_ff <= s2_valid_ff && s2_ff.slot.ok;
         end
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (clr_active_ff) begin
            if (clr_cnt_ff == CLR_W'(CLEAR_LEN - 1)) begin
               clr_active_ff <= 1'b0;
            end else begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff      <= s1_in;
         s2_ff      <= s2_in;
         s3_ff      <= s3_in;
         fw_slot_ff <= s2_ff.slot;
         fw_data_ff <= vsat.value;
      end
      if (rsp_load) begin
         rsp_ff <= advance ? result_in : skid_ff;
      end
      if (skid_load) begin
         skid_ff <= result_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_new_weight = rsp_ff.new_weight;
   assign rsp_saturated  = rsp_ff.saturated;

endmodule

`default_nettype wire

>>> hdl/sgdm_checker.sv
// port-level checks for the sgd momentum weight update block, bound to the top level
// depends on sgdm_pkg and sgd_momentum_weight_update
`default_nettype none

module sgdm_checker #(
   parameter int MATRIX_ELEMENTS = sgdm_pkg::DEF_MATRIX_ELEMENTS,
   parameter int MATRIX_COUNT    = sgdm_pkg::DEF_MATRIX_COUNT,
   parameter int VECTOR_LENGTH   = sgdm_pkg::DEF_VECTOR_LENGTH
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               req_mode,
   input logic [sgdm_pkg::SET_W-1:0]         req_set_index,
   input logic [sgdm_pkg::ELEM_W-1:0]        req_element_index,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [sgdm_pkg::DATA_W-1:0] rsp_new_weight,
   input logic                               rsp_saturated,
   input logic                               csr_psel,
   input logic                               csr_penable,
   input logic                               csr_pwrite,
   input logic                               csr_pready
);
   import sgdm_pkg::*;

   logic accept, csr_write, in_range;

   assign accept    = req_valid && !req_stall;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign in_range  = (req_mode == MODE_VECTOR)
                    ? ({20'd0, req_element_index} < 32'(VECTOR_LENGTH))
                    : (({28'd0, req_set_index} < 32'(MATRIX_COUNT)) &&
                       ({20'd0, req_element_index} < 32'(MATRIX_ELEMENTS)));

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_new_weight) && $stable(rsp_saturated))
      else $error("stalled result changed");

   // clear sweep starts right after reset with the output empty
   a_reset_clear: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("input not stalled or result present after reset");

   // scale recompute holds off input after a register write
   a_csr_recompute: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> req_stall)
      else $error("input taken while derived scales recompute");

   // read-modify-write interlock: no two back-to-back transfers on one entry
   a_rmw_interlock: assert property (@(posedge clock) disable iff (reset)
      accept |=> !(accept && in_range && req_mode == $past(req_mode) &&
                   req_element_index == $past(req_element_index) &&
                   (req_mode == MODE_VECTOR || req_set_index == $past(req_set_index))))
      else $error("same velocity entry transferred on consecutive cycles");

endmodule

bind sgd_momentum_weight_update sgdm_checker #(
   .MATRIX_ELEMENTS (MATRIX_ELEMENTS),
   .MATRIX_COUNT    (MATRIX_COUNT),
   .VECTOR_LENGTH   (VECTOR_LENGTH)
) u_sgdm_checker (.*);

`default_nettype wire
